[src/rgbwc_pkg.sv]
// Shared types, constants and helpers for the 3x3 RGB window convolution.
// No dependencies; the top level, line memory, lane and testbench import this package.
package rgbwc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_TAPS   = 9;
    localparam int TAP_W         = 4;
    localparam int PIX_W         = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int ACC_W         = 28;
    localparam int PROD_W        = 45;
    localparam int LVL_W         = 28;

    typedef logic [PIX_W-1:0] t_pix;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd6;

    localparam logic [1:0]       ROW_FULL = 2'd2;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(KERNEL_TAPS - 1);

    // 255.0 in Q.20
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(255) << 20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_GAIN,
        ST_CLAMP,
        ST_ALPHA,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic mac;
        logic gain;
        logic clamp;
        logic alpha;
    } t_lane_ctl;

    // Pick one Q8.8 coefficient out of the three packed registers.
    function automatic logic signed [15:0] coeff_at(input logic [TAP_W-1:0] idx,
                                                    input logic [63:0] lo,
                                                    input logic [63:0] mid,
                                                    input logic [15:0] hi);
        logic [15:0] bits;
        case (idx)
            4'd0:    bits = lo[15:0];
            4'd1:    bits = lo[31:16];
            4'd2:    bits = lo[47:32];
            4'd3:    bits = lo[63:48];
            4'd4:    bits = mid[15:0];
            4'd5:    bits = mid[31:16];
            4'd6:    bits = mid[47:32];
            4'd7:    bits = mid[63:48];
            default: bits = hi;
        endcase
        return $signed(bits);
    endfunction

endpackage

[src/rgbwc_if.sv]
// Pixel stream interfaces for the 3x3 RGB window convolution.
// Input and output channels with valid/ready handshake; no dependencies.
interface rgbwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;

    modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface rgbwc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;

    modport source (output valid, red_out, green_out, blue_out, row_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, row_end, output ready);
endinterface

[src/rgb_window_convolution.sv]
// Top level of the 3x3 RGB window convolution: configuration registers,
// raster counters, window, sequencer and output register.
// Depends on rgbwc_pkg, rgbwc_if, rgbwc_line_mem and rgbwc_lane.
//
// Usage:
//   Pixels enter on i_pix in raster order; frame_start marks column 0 of row 0.
//   Filtered pixels leave on o_pix, one per 3x3 window lying fully inside the
//   frame, row_end set on the last one of each output row.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
//   Each pixel reads and rewrites its column in the line memory; for a pixel
//   that yields an output the nine taps then run through one multiply-accumulate
//   per channel, one tap per cycle, followed by gain, clamp and alpha stages.
//   A pixel that yields no output returns to idle after the line memory write;
//   one that yields an output goes on through the output state, and the next
//   input is accepted only once the sequencer is back in idle.
//   The output register holds a result while the receiver stalls; the next
//   pixel is still taken, and its result waits for the register to drain.
//   Reset restores the register defaults and clears the row and column
//   counters; line memory contents stay undefined until written.
module rgb_window_convolution #(
    parameter int MAX_WIDTH = rgbwc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rgbwc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rgbwc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    rgbwc_in_if.sink                              i_pix,
    rgbwc_out_if.source                           o_pix
);
    import rgbwc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CW    = COL_W + 1;

    // configuration
    logic [63:0] r_coeff_lo, r_coeff_mid;
    logic [15:0] r_coeff_hi, r_gain;
    logic        r_invert;
    logic [8:0]  r_alpha;
    logic [10:0] r_width;

    // control
    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [1:0]       r_row, n_row;
    logic [COL_W-1:0] r_addr;
    logic             r_emit, r_row_end;
    logic [TAP_W-1:0] r_tap;
    t_pix             r_pix;
    t_pix             r_win [KERNEL_TAPS];

    logic             r_out_valid;
    logic [7:0]       r_out_red, r_out_green, r_out_blue;
    logic             r_out_row_end;

    logic [CW-1:0]    w_eff;
    logic [COL_W-1:0] cur_col;
    logic [1:0]       cur_row;
    logic [CW-1:0]    col_inc;
    logic             cur_emit, cur_row_end;
    logic             in_xfer, out_free;

    logic [2*PIX_W-1:0] rd_data;
    logic               mem_we;
    t_lane_ctl          lane_ctl;
    logic               ready_c, load_out;
    logic signed [15:0] coeff;
    logic [7:0]         res [3];

    // effective width, clamped to 3..MAX_WIDTH
    always_comb begin
        if (r_width < 11'd3) begin
            w_eff = CW'(3);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
    end

    // position of the incoming pixel and counters after it
    always_comb begin
        cur_col = i_pix.frame_start ? '0 : r_col;
        cur_row = i_pix.frame_start ? '0 : r_row;
        if ({1'b0, cur_col} >= w_eff) begin
            cur_col = '0;
            cur_row = (cur_row < ROW_FULL) ? cur_row + 2'd1 : cur_row;
        end
        cur_emit    = (cur_row == ROW_FULL) && (cur_col >= COL_W'(2));
        cur_row_end = ({1'b0, cur_col} == w_eff - CW'(1));
        col_inc     = {1'b0, cur_col} + CW'(1);
        n_col       = col_inc[COL_W-1:0];
        n_row       = cur_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (cur_row < ROW_FULL) ? cur_row + 2'd1 : cur_row;
        end
    end

    assign out_free = !r_out_valid || o_pix.ready;
    assign in_xfer  = i_pix.valid && ready_c;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_pix.valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = r_emit ? ST_MAC : ST_IDLE;
            ST_MAC:   if (r_tap == TAP_LAST) n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_ALPHA;
            ST_ALPHA: n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ready_c  = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        lane_ctl = '0;
        case (r_state)
            ST_IDLE:  ready_c = 1'b1;
            ST_LOAD: begin
                mem_we         = 1'b1;
                lane_ctl.clear = 1'b1;
            end
            ST_MAC:   lane_ctl.mac   = 1'b1;
            ST_GAIN:  lane_ctl.gain  = 1'b1;
            ST_CLAMP: lane_ctl.clamp = 1'b1;
            ST_ALPHA: lane_ctl.alpha = 1'b1;
            ST_OUT:   load_out = out_free;
            default:  ready_c = 1'b0;
        endcase
    end

    assign i_pix.ready = ready_c;

    rgbwc_line_mem #(
        .DEPTH(MAX_WIDTH)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_rd_en  (in_xfer),
        .i_rd_addr(cur_col),
        .o_rd_data(rd_data),
        .i_wr_en  (mem_we),
        .i_wr_addr(r_addr),
        .i_wr_data({rd_data[PIX_W-1:0], r_pix})
    );

    assign coeff = coeff_at(r_tap, r_coeff_lo, r_coeff_mid, r_coeff_hi);

    for (genvar c = 0; c < 3; c++) begin : g_lane
        rgbwc_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_pix_ch(r_win[r_tap][8*c +: 8]),
            .i_coeff (coeff),
            .i_gain  (r_gain),
            .i_invert(r_invert),
            .i_alpha (r_alpha),
            .o_res   (res[c])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
            r_coeff_lo  <= '0;
            r_coeff_mid <= 64'd256;
            r_coeff_hi  <= '0;
            r_gain      <= 16'd4096;
            r_invert    <= 1'b0;
            r_alpha     <= 9'd256;
            r_width     <= 11'd1024;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_state == ST_MAC) begin
                r_tap <= (r_tap == TAP_LAST) ? '0 : r_tap + TAP_W'(1);
            end else begin
                r_tap <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COEFF_LOW:  r_coeff_lo  <= i_cfg_data;
                    CFG_COEFF_MID:  r_coeff_mid <= i_cfg_data;
                    CFG_COEFF_HIGH: r_coeff_hi  <= i_cfg_data[15:0];
                    CFG_GAIN:       r_gain      <= i_cfg_data[15:0];
                    CFG_INVERT:     r_invert    <= i_cfg_data[0];
                    CFG_ALPHA:      r_alpha     <= i_cfg_data[8:0];
                    CFG_WIDTH:      r_width     <= i_cfg_data[10:0];
                    default:        r_invert    <= r_invert;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix     <= {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
            r_addr    <= cur_col;
            r_emit    <= cur_emit;
            r_row_end <= cur_row_end;
        end
        if (r_state == ST_LOAD) begin
            // shift the window left and drop the new column in on the right
            for (int r = 0; r < 3; r++) begin
                r_win[3*r]     <= r_win[3*r + 1];
                r_win[3*r + 1] <= r_win[3*r + 2];
            end
            r_win[2] <= rd_data[2*PIX_W-1:PIX_W];
            r_win[5] <= rd_data[PIX_W-1:0];
            r_win[8] <= r_pix;
        end
        if (load_out) begin
            r_out_red     <= res[0];
            r_out_green   <= res[1];
            r_out_blue    <= res[2];
            r_out_row_end <= r_row_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.red_out   = r_out_red;
    assign o_pix.green_out = r_out_green;
    assign o_pix.blue_out  = r_out_blue;
    assign o_pix.row_end   = r_out_row_end;

endmodule

[src/rgbwc_line_mem.sv]
// Two-line pixel store: one word per column holds the line above (low half)
// and the line two above (high half). Synchronous, registered read.
module rgbwc_line_mem #(
    parameter int DEPTH = rgbwc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output logic [2*rgbwc_pkg::PIX_W-1:0]       o_rd_data,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  logic [2*rgbwc_pkg::PIX_W-1:0]       i_wr_data
);
    import rgbwc_pkg::*;

    logic [2*PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[src/rgbwc_lane.sv]
// One color channel of the convolution datapath: tap-serial multiply-accumulate,
// gain product, clamp/invert and alpha scale. Uses rgbwc_pkg.
module rgbwc_lane (
    input  logic                         i_clk,
    input  rgbwc_pkg::t_lane_ctl         i_ctl,
    input  logic [7:0]                   i_pix_ch,
    input  logic signed [15:0]           i_coeff,
    input  logic [15:0]                  i_gain,
    input  logic                         i_invert,
    input  logic [8:0]                   i_alpha,
    output logic [7:0]                   o_res
);
    import rgbwc_pkg::*;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic [LVL_W-1:0]         r_lvl;
    logic [7:0]               r_res;

    logic signed [24:0]       tap_prod;
    logic [LVL_W-1:0]         lvl_clamped;
    logic [LVL_W+8:0]         scaled;
    logic [8:0]               scaled_q;

    assign tap_prod = $signed({1'b0, i_pix_ch}) * i_coeff;

    always_comb begin
        if (r_prod < 0) begin
            lvl_clamped = '0;
        end else if (r_prod > $signed({17'b0, LVL_TOP})) begin
            lvl_clamped = LVL_TOP;
        end else begin
            lvl_clamped = r_prod[LVL_W-1:0];
        end
    end

    assign scaled   = r_lvl * i_alpha;
    assign scaled_q = scaled[LVL_W+8:LVL_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + ACC_W'(tap_prod);
        end
        if (i_ctl.gain) begin
            r_prod <= r_acc * $signed({1'b0, i_gain});
        end
        if (i_ctl.clamp) begin
            r_lvl <= i_invert ? (LVL_TOP - lvl_clamped) : lvl_clamped;
        end
        if (i_ctl.alpha) begin
            // saturate alpha above unity
            r_res <= (scaled_q > 9'd255) ? 8'd255 : scaled_q[7:0];
        end
    end

    assign o_res = r_res;

endmodule

[src/rgbwc_checker.sv]
// Port-level checks for rgb_window_convolution, attached by bind.
// Sees only the top-level handshake and output payload.
module rgbwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [24:0] i_out_data
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

    // one pixel in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

endmodule

bind rgb_window_convolution rgbwc_checker u_rgbwc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pix.valid),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_pix.valid),
    .i_out_ready(o_pix.ready),
    .i_out_data ({o_pix.row_end, o_pix.blue_out, o_pix.green_out, o_pix.red_out})
);

[tb/tb_rgb_window_convolution.sv]
// Self-checking testbench for the 3x3 RGB window convolution.
// Needs rgbwc_pkg, the rgbwc_in_if/rgbwc_out_if interfaces and the RTL under src.
// Drives random pixel streams under changing settings, predicts each filtered pixel.
module tb_rgb_window_convolution;
    import rgbwc_pkg::*;

    localparam int  SETTLE_CYCLES = 32;
    localparam int  LIMIT_CYCLES  = 3_000_000;
    localparam int  WIDE_PIXELS   = 300;
    localparam int  RANDOM_PHASES = 9;
    localparam longint LEVEL_TOP  = longint'(255) * 1048576;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
    } t_filtered_pixel;

    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_mode;

    // Predicts filtered pixels from accepted input pixels and checks results in order.
    class window_filter_check;
        logic [63:0] coeff_low;
        logic [63:0] coeff_mid;
        logic [15:0] coeff_high;
        logic [15:0] gain;
        logic        invert;
        logic [8:0]  alpha;
        logic [10:0] width_reg;
        logic [23:0] line_mem [2*MAX_WIDTH_DEF];
        logic [23:0] window [9];
        int unsigned col_cnt;
        int unsigned row_cnt;
        t_filtered_pixel expected_pixels [$];
        int errors;

        function new();
            coeff_low  = 64'd0;
            coeff_mid  = 64'd256;
            coeff_high = 16'd0;
            gain       = 16'd4096;
            invert     = 1'b0;
            alpha      = 9'd256;
            width_reg  = 11'd1024;
            foreach (line_mem[k]) line_mem[k] = '0;
            foreach (window[k]) window[k] = '0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COEFF_LOW:  coeff_low  = data;
                CFG_COEFF_MID:  coeff_mid  = data;
                CFG_COEFF_HIGH: coeff_high = data[15:0];
                CFG_GAIN:       gain       = data[15:0];
                CFG_INVERT:     invert     = data[0];
                CFG_ALPHA:      alpha      = data[8:0];
                CFG_WIDTH:      width_reg  = data[10:0];
                default: ;
            endcase
        endfunction

        function longint tap_coeff(int idx);
            logic [15:0] bits;
            if (idx < 4)
                bits = coeff_low[16*idx +: 16];
            else if (idx < 8)
                bits = coeff_mid[16*(idx-4) +: 16];
            else
                bits = coeff_high;
            return longint'($signed(bits));
        endfunction

        function logic [7:0] channel_level(int shift);
            longint acc;
            longint level;
            acc = 0;
            for (int i = 0; i < KERNEL_TAPS; i++)
                acc += longint'(window[i][shift +: 8]) * tap_coeff(i);
            level = acc * longint'(gain);
            if (level < 0)
                level = 0;
            if (level > LEVEL_TOP)
                level = LEVEL_TOP;
            if (invert)
                level = LEVEL_TOP - level;
            level = (level * longint'(alpha)) >>> 28;
            if (level > 255)
                level = 255;
            return level[7:0];
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
            int unsigned w;
            int unsigned c;
            logic [23:0] pix;
            logic [23:0] mid_v;
            logic [23:0] top_v;
            t_filtered_pixel e;
            w = 32'(width_reg);
            if (w < 3)
                w = 3;
            if (w > MAX_WIDTH_DEF)
                w = MAX_WIDTH_DEF;
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            // a lowered width ends the current row early
            if (col_cnt >= w) begin
                col_cnt = 0;
                if (row_cnt < 2)
                    row_cnt++;
            end
            c = col_cnt;
            pix = {b, g, r};
            mid_v = line_mem[c];
            top_v = line_mem[MAX_WIDTH_DEF + c];
            line_mem[MAX_WIDTH_DEF + c] = mid_v;
            line_mem[c] = pix;
            for (int k = 0; k < 3; k++) begin
                window[3*k]     = window[3*k + 1];
                window[3*k + 1] = window[3*k + 2];
            end
            window[2] = top_v;
            window[5] = mid_v;
            window[8] = pix;
            if (row_cnt >= 2 && c >= 2) begin
                e.red     = channel_level(0);
                e.green   = channel_level(8);
                e.blue    = channel_level(16);
                e.row_end = (c == w - 1);
                expected_pixels.push_back(e);
            end
            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                if (row_cnt < 2)
                    row_cnt++;
            end
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                         act_v);
            end
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic re);
            t_filtered_pixel e;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: expected nothing, actual %0d %0d %0d %0d",
                         $time, r, g, b, re);
                return;
            end
            e = expected_pixels.pop_front();
            compare_field("red_out", int'(e.red), int'(r));
            compare_field("green_out", int'(e.green), int'(g));
            compare_field("blue_out", int'(e.blue), int'(b));
            compare_field("row_end", int'(e.row_end), int'(re));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rgbwc_in_if  pix_in ();
    rgbwc_out_if pix_out ();

    window_filter_check conv_check;
    int          burst_left;
    int          cur_width;
    t_rx_mode    rx_mode;
    int          rx_left;

    rgb_window_convolution DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stall pattern: switch between streaming, coin flips, sparse and held stalls.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(5, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_STREAM: pix_out.ready <= 1'b1;
            RX_COIN:   pix_out.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: pix_out.ready <= ($urandom_range(0, 5) == 0);
            default:   pix_out.ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_in.valid && pix_in.ready)
            conv_check.note_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in,
                                  pix_in.frame_start);
        if (i_rst_n && pix_out.valid && pix_out.ready)
            conv_check.check_result(pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                                    pix_out.row_end);
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                pix_in.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        pix_in.valid       <= 1'b1;
        pix_in.red_in      <= r;
        pix_in.green_in    <= g;
        pix_in.blue_in     <= b;
        pix_in.frame_start <= fs;
        // hold until the transfer
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    task automatic stream_pixels(int n_items, bit restart, bit noisy);
        logic fs;
        for (int k = 0; k < n_items; k++) begin
            fs = (k == 0 && restart) || (noisy && $urandom_range(0, 199) == 0);
            send_pixel(pick_level(), pick_level(), pick_level(), fs);
        end
    endtask

    // Stop sending and let every expected pixel come out, plus the tail of the pipeline.
    task automatic wait_for_drain();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (conv_check.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        conv_check.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [63:0] lo, logic [63:0] mid, logic [15:0] hi,
                                  logic [15:0] gain_v, logic inv, logic [8:0] alpha_v,
                                  logic [10:0] width_v);
        write_reg(CFG_COEFF_LOW, lo);
        write_reg(CFG_COEFF_MID, mid);
        write_reg(CFG_COEFF_HIGH, 64'(hi));
        write_reg(CFG_GAIN, 64'(gain_v));
        write_reg(CFG_INVERT, 64'(inv));
        write_reg(CFG_ALPHA, 64'(alpha_v));
        write_reg(CFG_WIDTH, 64'(width_v));
        cur_width = (width_v < 3) ? 3 : (width_v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_v;
    endtask

    // A wider row would read line entries never written, so force a new frame then.
    task automatic random_settings(output bit restart);
        logic [15:0] taps [9];
        logic [15:0] gain_v;
        logic [8:0]  alpha_v;
        logic [10:0] width_v;
        int          t;
        int          old_width;
        bit          wild;
        wild = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < 9; k++) begin
            t = $urandom_range(0, 280) - 80;
            taps[k] = wild ? 16'($urandom_range(0, 65535)) : t[15:0];
        end
        gain_v = wild ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1024, 6144));
        case ($urandom_range(0, 4))
            0:       alpha_v = 9'd256;
            1:       alpha_v = 9'($urandom_range(257, 511));
            default: alpha_v = 9'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 9))
            0:       width_v = 11'($urandom_range(0, 2));
            1:       width_v = 11'($urandom_range(17, 30));
            default: width_v = 11'($urandom_range(3, 16));
        endcase
        old_width = cur_width;
        apply_settings({taps[3], taps[2], taps[1], taps[0]},
                       {taps[7], taps[6], taps[5], taps[4]}, taps[8], gain_v,
                       1'($urandom_range(0, 1)), alpha_v, width_v);
        restart = (cur_width > old_width) || ($urandom_range(0, 1) == 1);
    endtask

    initial begin
        bit restart;
        logic [7:0] lv [4];
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        i_clk              = 1'b0;
        pix_in.valid       = 1'b0;
        pix_in.red_in      = '0;
        pix_in.green_in    = '0;
        pix_in.blue_in     = '0;
        pix_in.frame_start = 1'b0;
        pix_out.ready      = 1'b0;
        burst_left         = 0;
        rx_left            = 0;
        rx_mode            = RX_STREAM;
        lv[0] = 8'h00;
        lv[1] = 8'hFF;
        lv[2] = 8'hAA;
        lv[3] = 8'h55;
        conv_check = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default kernel passes the centre pixel; narrowest rows, restart mid-row.
        write_reg(CFG_WIDTH, 64'd3);
        cur_width = 3;
        for (int k = 0; k < 22; k++)
            send_pixel(lv[k % 4], lv[(k + 1) % 4], lv[(k + 2) % 4], k == 0 || k == 13);
        wait_for_drain();

        // Width beyond the line store acts as the full width: a long first row, no output.
        apply_settings({4{16'h001C}}, {4{16'h001C}}, 16'h001C, 16'd4096, 1'b0, 9'd256,
                       11'd2047);
        stream_pixels(WIDE_PIXELS, 1'b1, 1'b0);
        wait_for_drain();

        // Saturating extremes and the short widths that act as three.
        apply_settings({4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF, 16'hFFFF, 1'b0, 9'd511, 11'd0);
        stream_pixels(40, 1'b1, 1'b1);
        wait_for_drain();
        apply_settings({4{16'h8000}}, {4{16'h8000}}, 16'h8000, 16'hFFFF, 1'b1, 9'd256, 11'd1);
        stream_pixels(40, 1'b1, 1'b1);
        wait_for_drain();
        apply_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'd0, 1'b1,
                       9'd128, 11'd2);
        stream_pixels(40, 1'b1, 1'b1);
        wait_for_drain();

        // Sharpen kernel; end mid-row, then narrow the rows without a new frame.
        apply_settings({16'hFF00, 16'h0000, 16'hFF00, 16'h0000},
                       {16'hFF00, 16'h0000, 16'hFF00, 16'h0500}, 16'h0000, 16'd4096, 1'b0,
                       9'd200, 11'd20);
        stream_pixels(55, 1'b1, 1'b0);
        wait_for_drain();
        write_reg(CFG_WIDTH, 64'd8);
        cur_width = 8;
        stream_pixels(60, 1'b0, 1'b1);
        wait_for_drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings(restart);
            stream_pixels($urandom_range(40, 90), restart, 1'b1);
            wait_for_drain();
        end

        if (conv_check.errors == 0)
            $display("rgb_window_convolution regression: pass");
        else
            $display("rgb_window_convolution regression: fail");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("rgb_window_convolution regression: fail");
        $finish;
    end

endmodule

[files.f]
src/rgbwc_pkg.sv
src/rgbwc_if.sv
src/rgbwc_line_mem.sv
src/rgbwc_lane.sv
src/rgb_window_convolution.sv
src/rgbwc_checker.sv
tb/tb_rgb_window_convolution.sv
